FILE: hdl/sm3_hash_engine_macros.svh
// Assertion macros shared by the SM3 hash engine modules
`ifndef SM3_HASH_ENGINE_MACROS_SVH
`define SM3_HASH_ENGINE_MACROS_SVH

// Assert that an implication holds on every clock edge outside reset
`define SM3_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Assert that a condition holds in the cycle after a trigger
`define SM3_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hdl/sm3_pkg.sv
// Package with SM3 constants, types and round helper functions
package sm3_pkg;

  localparam int CountWidthDefault = 61;
  localparam int QueueDepth = 4;

  localparam logic [31:0] TJ_LOW  = 32'h79CC4519;
  localparam logic [31:0] TJ_HIGH = 32'h7A879D8A;
  localparam logic [7:0]  PAD_MARK = 8'h80;

  localparam logic [31:0] IV0 = 32'h7380166F;
  localparam logic [31:0] IV1 = 32'h4914B2B9;
  localparam logic [31:0] IV2 = 32'h172442D7;
  localparam logic [31:0] IV3 = 32'hDA8A0600;
  localparam logic [31:0] IV4 = 32'hA96F30BC;
  localparam logic [31:0] IV5 = 32'h163138AA;
  localparam logic [31:0] IV6 = 32'hE38DEE4D;
  localparam logic [31:0] IV7 = 32'hB0FB0E4E;

  // Queue entry between the classifier and the core
  typedef struct packed {
    logic       finish;
    logic [7:0] data;
  } sm3_cmd_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic logic [31:0] p0(input logic [31:0] x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic logic [31:0] p1(input logic [31:0] x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

  function automatic logic [31:0] iv_word(input logic [2:0] i);
    logic [31:0] v;
    case (i)
      3'd0: v = IV0;
      3'd1: v = IV1;
      3'd2: v = IV2;
      3'd3: v = IV3;
      3'd4: v = IV4;
      3'd5: v = IV5;
      3'd6: v = IV6;
      default: v = IV7;
    endcase
    return v;
  endfunction

endpackage

FILE: hdl/sm3_front.sv
// Front end: accepts items and queues them for the compression core
module sm3_front import sm3_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       mode,
  input  logic [7:0] data_byte,
  output logic       cmd_valid,
  input  logic       cmd_ready,
  output sm3_cmd_t   cmd
);
  localparam int AW = $clog2(QueueDepth);

  sm3_cmd_t       queue [QueueDepth];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [AW:0]    count;
  logic           push;
  logic           pop;

  assign in_ready  = (count != (AW+1)'(QueueDepth));
  assign cmd_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = queue[rd_ptr];

  // Store the classified item
  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr].finish <= mode;
      queue[wr_ptr].data   <= data_byte;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

`include "sm3_hash_engine_macros.svh"
  `SM3_ASSERT_IMPL(a_no_overflow, clk, rst, 1'b1, count <= (AW+1)'(QueueDepth))
  `SM3_ASSERT_NEXT(a_push_grows, clk, rst, push && !pop, count != '0)
  `SM3_ASSERT_IMPL(a_full_stall, clk, rst, count == (AW+1)'(QueueDepth), !in_ready)
endmodule

FILE: hdl/sm3_core.sv
// Back end: block buffer, padding sequencer, 64-round compression, digest output
module sm3_core import sm3_pkg::*; #(
  parameter int COUNT_WIDTH = CountWidthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  sm3_cmd_t    cmd,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_PAD   = 7'b0000010,
    S_LOAD  = 7'b0000100,
    S_ROUND = 7'b0001000,
    S_FOLD  = 7'b0010000,
    S_OUT   = 7'b0100000,
    S_SKID  = 7'b1000000
  } state_t;

  state_t state, state_next;

  // Block held as sixteen big-endian words, written one byte lane at a time
  logic [31:0] buffer [16];
  logic [5:0]  fill;
  logic [COUNT_WIDTH-1:0] byte_count;
  logic [31:0] cv [8];
  logic [31:0] w  [16];
  logic [31:0] r  [8];
  logic [5:0]  round;
  logic [5:0]  pad_idx;
  logic        finishing;
  logic        second_pass;
  logic [3:0]  load_idx;
  logic [2:0]  out_idx;
  logic [63:0] bit_len;
  logic [7:0]  pad_byte;

  assign bit_len = 64'(byte_count) << 3;
  assign cmd_ready = (state == S_IDLE);

  // Pick the padding byte for the current position
  always_comb begin
    if (pad_idx == fill && !second_pass) pad_byte = PAD_MARK;
    else if (pad_idx >= 6'd56 && !(fill >= 6'd56 && !second_pass))
      pad_byte = bit_len[8*(7-(pad_idx-6'd56)) +: 8];
    else pad_byte = 8'h00;
  end

  // Round datapath
  logic [31:0] tj, a12, ss1, ss2, ff, gg, tt1, tt2, nw;
  always_comb begin
    tj  = (round < 6'd16) ? TJ_LOW : TJ_HIGH;
    a12 = rotl(r[0], 5'd12);
    ss1 = rotl(a12 + r[4] + rotl(tj, round[4:0]), 5'd7);
    ss2 = ss1 ^ a12;
    if (round < 6'd16) begin
      ff = r[0] ^ r[1] ^ r[2];
      gg = r[4] ^ r[5] ^ r[6];
    end else begin
      ff = (r[0] & r[1]) | (r[0] & r[2]) | (r[1] & r[2]);
      gg = (r[4] & r[5]) | (~r[4] & r[6]);
    end
    tt1 = ff + r[3] + ss2 + (w[0] ^ w[4]);
    tt2 = gg + r[7] + ss1 + w[0];
    nw  = p1(w[0] ^ w[7] ^ rotl(w[13], 5'd15)) ^ rotl(w[3], 5'd7) ^ w[10];
  end

  // Sequence the core
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (cmd_valid) begin
        if (cmd.finish) state_next = S_PAD;
        else if (fill == 6'd63) state_next = S_LOAD;
      end
      S_PAD:   if (pad_idx == 6'd63) state_next = S_LOAD;
      S_LOAD:  if (load_idx == 4'd15) state_next = S_ROUND;
      S_ROUND: if (round == 6'd63) state_next = S_FOLD;
      S_FOLD: begin
        if (!finishing) state_next = S_IDLE;
        else if (fill >= 6'd56 && !second_pass) state_next = S_PAD;
        else state_next = S_OUT;
      end
      S_OUT:  if (out_ready && out_idx == 3'd7) state_next = S_IDLE;
      S_SKID: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill <= '0;
      byte_count <= '0;
      finishing <= 1'b0;
      second_pass <= 1'b0;
      pad_idx <= '0;
      load_idx <= '0;
      round <= '0;
      out_idx <= '0;
      for (int i = 0; i < 8; i++) cv[i] <= iv_word(3'(i));
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: if (cmd_valid) begin
          if (cmd.finish) begin
            finishing <= 1'b1;
            second_pass <= 1'b0;
            pad_idx <= '0;
          end else begin
            fill <= fill + 1'b1;
            byte_count <= byte_count + 1'b1;
            finishing <= 1'b0;
          end
          load_idx <= '0;
        end
        S_PAD: begin
          pad_idx <= pad_idx + 1'b1;
          load_idx <= '0;
        end
        S_LOAD: begin
          load_idx <= load_idx + 1'b1;
          round <= '0;
        end
        S_ROUND: round <= round + 1'b1;
        S_FOLD: begin
          for (int i = 0; i < 8; i++) cv[i] <= cv[i] ^ r[i];
          if (finishing && fill >= 6'd56 && !second_pass) begin
            second_pass <= 1'b1;
            pad_idx <= '0;
          end
          out_idx <= '0;
        end
        S_OUT: if (out_ready) begin
          out_idx <= out_idx + 1'b1;
          if (out_idx == 3'd7) begin
            for (int i = 0; i < 8; i++) cv[i] <= iv_word(3'(i));
            fill <= '0;
            byte_count <= '0;
            finishing <= 1'b0;
            second_pass <= 1'b0;
          end
        end
        S_SKID: ;
        default: ;
      endcase
    end
  end

  // Write the block buffer and run the datapath registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && cmd_valid && !cmd.finish)
      buffer[fill[5:2]][{~fill[1:0], 3'b000} +: 8] <= cmd.data;
    // Keep message bytes; pad only from the marker position on, or all of a second block
    if (state == S_PAD && (second_pass || pad_idx >= fill))
      buffer[pad_idx[5:2]][{~pad_idx[1:0], 3'b000} +: 8] <= pad_byte;
    if (state == S_LOAD) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= buffer[load_idx];
      for (int i = 0; i < 8; i++) r[i] <= cv[i];
    end
    if (state == S_ROUND) begin
      r[3] <= r[2];
      r[2] <= rotl(r[1], 5'd9);
      r[1] <= r[0];
      r[0] <= tt1;
      r[7] <= r[6];
      r[6] <= rotl(r[5], 5'd19);
      r[5] <= r[4];
      r[4] <= p0(tt2);
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= nw;
    end
  end

  assign out_valid   = (state == S_OUT);
  assign digest_word = cv[out_idx];
  assign word_index  = out_idx;
  assign last_word   = (out_idx == 3'd7);

`include "sm3_hash_engine_macros.svh"
  `SM3_ASSERT_IMPL(a_out_only_finish, clk, rst, out_valid, finishing)
  `SM3_ASSERT_IMPL(a_ready_idle, clk, rst, cmd_ready, !out_valid)
  `SM3_ASSERT_NEXT(a_last_returns, clk, rst, out_valid && out_ready && last_word,
                   state == S_IDLE && fill == '0)
endmodule

FILE: hdl/sm3_hash_engine.sv
// Top level of the SM3 hash engine: byte queue feeding the compression core
//  channel | direction | handshake             | payload
//  in      | input     | in_valid / in_ready   | mode, data_byte
//  out     | output    | out_valid / out_ready | digest_word, word_index, last_word
// A data byte is written to the block buffer in S_IDLE; the 64th byte of a block then
// runs the load, round (one round per cycle in the shared round unit) and fold states.
// A finish item pads the block and compresses it, twice when 56 or more bytes are
// held, then outputs the eight digest words. A 4-entry queue absorbs input while
// the core compresses. Reset is synchronous and loads the IV; no clearing pass.
// Output stalls hold the core; input stalls only when the queue is full.
module sm3_hash_engine import sm3_pkg::*; #(
  parameter int COUNT_WIDTH = CountWidthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  logic     cmd_valid;
  logic     cmd_ready;
  sm3_cmd_t cmd;

  sm3_front u_front (
    .clk, .rst, .in_valid, .in_ready, .mode, .data_byte,
    .cmd_valid, .cmd_ready, .cmd
  );

  sm3_core #(.COUNT_WIDTH(COUNT_WIDTH)) u_core (
    .clk, .rst, .cmd_valid, .cmd_ready, .cmd,
    .out_valid, .out_ready, .digest_word, .word_index, .last_word
  );
endmodule
